>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define LZD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define LZD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/lzd_pkg.sv
// ----------------------------------------------------------------------------
// lzd_pkg
// shared types and constants of the lz token decompressor
// ----------------------------------------------------------------------------
package lzd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DIST_W  = 12;
  localparam int unsigned COUNT_W = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } lzd_state_t;

  // decoded token, valid in the cycle the token transaction completes
  typedef struct packed {
    logic               literal;
    logic [LEN_W-1:0]   count;
    logic [BYTE_W-1:0]  lit_data;
    logic [DIST_W-1:0]  back_dist;
    logic               fin;
    logic [COUNT_W-1:0] count_next;
  } lzd_dec_t;

endpackage

>>> hdl/lzd_token_if.sv
// ----------------------------------------------------------------------------
// lzd_token_if
// token channel: two token bytes with valid / ready
// ----------------------------------------------------------------------------
interface lzd_token_if import lzd_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] second_byte;

  modport source (output valid, output first_byte, output second_byte, input ready);
  modport sink   (input valid, input first_byte, input second_byte, output ready);

endinterface

>>> hdl/lzd_byte_if.sv
// ----------------------------------------------------------------------------
// lzd_byte_if
// output channel: one decompressed byte and its flags with valid / ready
// ----------------------------------------------------------------------------
interface lzd_byte_if import lzd_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_of_run;
  logic              finished;

  modport source (output valid, output data_byte, output last_of_run, output finished,
                  input ready);
  modport sink   (input valid, input data_byte, input last_of_run, input finished,
                  output ready);

endinterface

>>> hdl/lzd_decode.sv
// ----------------------------------------------------------------------------
// lzd_decode
// splits a token and works out its byte count and the end-of-output check
// ----------------------------------------------------------------------------
module lzd_decode import lzd_pkg::*; (
  input  logic [BYTE_W-1:0]  first_byte,
  input  logic [BYTE_W-1:0]  second_byte,
  input  logic [COUNT_W-1:0] bytes_written,
  input  logic [COUNT_W-1:0] output_length,
  output lzd_dec_t           dec
);

  logic [COUNT_W:0] pos_end;

  always_comb begin
    dec.literal   = (first_byte == '0);
    dec.lit_data  = second_byte;
    dec.back_dist = {first_byte[LEN_W-1:0], second_byte};
    dec.count     = dec.literal ? LEN_W'(1) : first_byte[BYTE_W-1:BYTE_W-LEN_W];

    // exact count for the end check, saturated copy for the counter
    pos_end        = {1'b0, bytes_written} + (COUNT_W+1)'(dec.count);
    dec.fin        = (pos_end >= {1'b0, output_length});
    dec.count_next = pos_end[COUNT_W] ? COUNT_MAX : pos_end[COUNT_W-1:0];
  end

endmodule

>>> hdl/lz_token_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lz_token_decompressor_unit
// lz token decoder with a history window and a byte-wide output stream
// ----------------------------------------------------------------------------
// usage
// - token: two-byte tokens; first byte zero gives a literal (second byte),
//   else high nibble = copy length, low nibble + second byte = back distance
// - bytes_out: one decompressed byte per transaction, last_of_run on the
//   final byte of a token, finished on the final byte of the ending token
// - cfg_write / cfg_data: sets the expected output length and restarts
//   decoding; the history window keeps its contents
// - a token producing n bytes holds the token channel until its last byte
//   issues: the token is taken, then one window read per byte through the
//   single read port, paused on a stall; zero-length copies never hold it
// - first byte reaches bytes_out via the state, read stage and output register
// - a stalled receiver holds the output register, the byte behind it waits
//   in the read stage, and the copy sequencer pauses until space frees up
// - reset clears control state only; window slots never written since
//   reset read as zero through a fill count, so no clearing pass is needed
// - tokens taken after the ending token give no bytes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lz_token_decompressor_unit import lzd_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [COUNT_W-1:0] cfg_data,
  lzd_token_if.sink          token,
  lzd_byte_if.source         bytes_out
);

  localparam int unsigned SLOT_W = $clog2(WINDOW_DEPTH);
  localparam int unsigned EXT_W  = SLOT_W + 1;
  localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [EXT_W-1:0]  DEPTH_EXT = EXT_W'(WINDOW_DEPTH);
  localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(WINDOW_DEPTH);

  // control state
  lzd_state_t         state, state_next;
  logic [COUNT_W-1:0] output_length;
  logic [COUNT_W-1:0] bytes_written;
  logic               done_flag;
  logic [FILL_W-1:0]  fill;        // slots [0, fill) written since reset
  logic [LEN_W-1:0]   remain;      // bytes left to issue for this token
  logic [SLOT_W-1:0]  wr_slot;     // slot of the next byte to issue
  logic [SLOT_W-1:0]  rd_slot;     // window slot it copies from

  // token context
  logic               tok_literal;
  logic [BYTE_W-1:0]  tok_lit_data;
  logic               tok_fin;

  // read stage
  logic               b_valid;
  logic [SLOT_W-1:0]  b_slot;
  logic               b_last;
  logic               b_fin;
  logic               b_fwd;
  logic [BYTE_W-1:0]  b_fwd_data;
  logic               b_zero;
  logic [BYTE_W-1:0]  mem_rdata;
  logic [BYTE_W-1:0]  b_data;
  logic               b_move;

  // output register
  logic               out_valid;
  logic [BYTE_W-1:0]  out_data;
  logic               out_last;
  logic               out_fin;

  // handshake and sequencing
  logic               tok_acc;
  logic               start;
  logic               issue;
  lzd_dec_t           dec;
  logic [EXT_W-1:0]   rd_diff;
  logic [SLOT_W-1:0]  rd_init;

  logic [BYTE_W-1:0]  window [WINDOW_DEPTH];

  lzd_decode u_decode (
    .first_byte    (token.first_byte),
    .second_byte   (token.second_byte),
    .bytes_written (bytes_written),
    .output_length (output_length),
    .dec           (dec)
  );

  // copy source: current slot minus distance, wrapped into the window
  always_comb begin
    rd_diff = EXT_W'(wr_slot) - EXT_W'(dec.back_dist);
    if (rd_diff[SLOT_W]) begin
      rd_init = SLOT_W'(rd_diff + DEPTH_EXT);
    end else begin
      rd_init = rd_diff[SLOT_W-1:0];
    end
  end

  // read stage drains when the output register is empty or being taken
  assign b_move = b_valid && (!out_valid || bytes_out.ready);
  // byte seen by the read stage: forwarded, never written, or from the window
  assign b_data = b_fwd ? b_fwd_data : (b_zero ? '0 : mem_rdata);

  // sequencer outputs
  always_comb begin
    token.ready = (state == ST_IDLE);
    tok_acc     = token.valid && token.ready;
    start       = tok_acc && !done_flag && (dec.count != '0);
    issue       = (state == ST_RUN) && (!b_valid || b_move);
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue && (remain == LEN_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // length register, output count and end flag
  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
      bytes_written <= '0;
      done_flag     <= 1'b0;
    end else if (cfg_write) begin
      output_length <= cfg_data;
      bytes_written <= '0;
      done_flag     <= 1'b0;
    end else if (tok_acc && !done_flag) begin
      bytes_written <= dec.count_next;
      if (dec.fin) begin
        done_flag <= 1'b1;
      end
    end
  end

  // copy pointers and byte countdown
  always_ff @(posedge clk) begin
    if (rst) begin
      remain  <= '0;
      wr_slot <= '0;
      rd_slot <= '0;
    end else begin
      if (cfg_write) begin
        wr_slot <= '0;
      end else if (issue) begin
        wr_slot <= (wr_slot == SLOT_LAST) ? '0 : wr_slot + SLOT_W'(1);
      end
      if (start) begin
        remain  <= dec.count;
        rd_slot <= rd_init;
      end else if (issue) begin
        remain  <= remain - LEN_W'(1);
        rd_slot <= (rd_slot == SLOT_LAST) ? '0 : rd_slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      tok_literal  <= dec.literal;
      tok_lit_data <= dec.lit_data;
      tok_fin      <= dec.fin;
    end
  end

  // fill count grows as writes reach the first unwritten slot
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (b_move && (FILL_W'(b_slot) == fill) && (fill != FILL_MAX)) begin
      fill <= fill + FILL_W'(1);
    end
  end

  // history window: one write and one registered read per cycle, each only while a byte moves or issues
  always_ff @(posedge clk) begin
    if (b_move) begin
      window[b_slot] <= b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      mem_rdata <= window[rd_slot];
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (issue) begin
      b_valid <= 1'b1;
    end else if (b_move) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      b_slot <= wr_slot;
      b_last <= (remain == LEN_W'(1));
      b_fin  <= tok_fin && (remain == LEN_W'(1));
      // distance one reads the slot being written this very cycle
      b_fwd      <= tok_literal || (b_move && (b_slot == rd_slot));
      b_fwd_data <= tok_literal ? tok_lit_data : b_data;
      b_zero     <= (FILL_W'(rd_slot) >= fill);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_move) begin
      out_valid <= 1'b1;
    end else if (bytes_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      out_data <= b_data;
      out_last <= b_last;
      out_fin  <= b_fin;
    end
  end

  assign bytes_out.valid       = out_valid;
  assign bytes_out.data_byte   = out_data;
  assign bytes_out.last_of_run = out_last;
  assign bytes_out.finished    = out_fin;

  // checks
  `LZD_ASSERT(a_fin_on_last, (bytes_out.valid && bytes_out.finished) |-> bytes_out.last_of_run, "finished without last_of_run")
  `LZD_ASSERT_NEXT(a_stall_holds_stage, b_valid && out_valid && !bytes_out.ready, b_valid, "read stage lost a byte during stall")
  `LZD_ASSERT_NEXT(a_done_ignores, tok_acc && done_flag, state == ST_IDLE, "token after end started a copy")
  `LZD_ASSERT(a_fill_bound, fill <= FILL_MAX, "fill count beyond window depth")

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the lz token decompressor against an in-bench decoder with its own
// history window; tokens come from a queue through a clocked driver, the
// byte stream is checked transaction by transaction under several idle mixes
// ----------------------------------------------------------------------------
module testbench import lzd_pkg::*; ();

  localparam int unsigned WIN_DEPTH     = 4096;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned DRAIN_LIMIT   = 50000;

  // idle mixes, one per phase
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mix_t;

  typedef struct packed {
    logic [BYTE_W-1:0] first;
    logic [BYTE_W-1:0] second;
  } token_t;

  // one predicted output byte with its flags
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    logic              fin;
  } out_byte_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write;
  logic [COUNT_W-1:0] cfg_data;

  lzd_token_if tok_if ();
  lzd_byte_if  out_if ();

  lz_token_decompressor_unit #(
    .WINDOW_DEPTH (WIN_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .token     (tok_if),
    .bytes_out (out_if)
  );

  always #4 clk = ~clk;

  // tokens waiting for the driver and bytes waiting for the checker
  token_t    token_q[$];
  out_byte_t byte_exp_q[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches;

  // decoder state kept by the bench
  logic [BYTE_W-1:0]  hist_win [WIN_DEPTH];
  logic [COUNT_W-1:0] out_count;
  logic [COUNT_W-1:0] out_limit;
  logic               halted;

  // byte count of the queued tokens, used only to shape each phase
  int unsigned gen_bytes;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // decode one accepted token and queue the bytes it must produce
  task automatic decode_token(input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2);
    int unsigned       pos;
    int unsigned       n;
    logic [LEN_W-1:0]  run_len;
    logic [DIST_W-1:0] back_dist;
    logic [DIST_W-1:0] slot;
    logic [BYTE_W-1:0] vals [16];
    logic              fin;
    out_byte_t         ob;

    // tokens after the ending one are dropped
    if (halted) return;
    pos = 32'(out_count);
    n = 0;
    if (b1 == 8'h00) begin
      hist_win[pos % WIN_DEPTH] = b2;
      vals[0] = b2;
      pos++;
      n = 1;
    end else begin
      run_len = b1[7:4];
      back_dist = {b1[3:0], b2};
      // byte by byte, so an overlapping copy repeats what it just wrote
      for (int k = 0; k < run_len; k++) begin
        slot = DIST_W'(pos) - back_dist;
        vals[k] = hist_win[slot];
        hist_win[pos % WIN_DEPTH] = vals[k];
        pos++;
      end
      n = 32'(run_len);
    end
    // end check on the exact count, stored count saturates
    fin = (pos >= out_limit);
    if (fin) halted = 1'b1;
    out_count = (pos > COUNT_MAX) ? COUNT_MAX : COUNT_W'(pos);
    for (int k = 0; k < n; k++) begin
      ob.data = vals[k];
      ob.last = (k == n - 1);
      ob.fin  = (k == n - 1) && fin;
      byte_exp_q.push_back(ob);
    end
  endtask

  // ---------------------------------------------------------------------------
  // token driver: new token only when the slot is free, random sender gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : token_driver
    token_t t;
    if (rst) begin
      tok_if.valid       <= 1'b0;
      tok_if.first_byte  <= '0;
      tok_if.second_byte <= '0;
    end else if (!tok_if.valid || tok_if.ready) begin
      if (token_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        t = token_q.pop_front();
        tok_if.first_byte  <= t.first;
        tok_if.second_byte <= t.second;
        tok_if.valid       <= 1'b1;
      end else begin
        tok_if.valid <= 1'b0;
      end
    end
  end

  // token monitor: every accepted token runs through the bench decoder
  always @(posedge clk) begin
    if (!rst && tok_if.valid && tok_if.ready) begin
      decode_token(tok_if.first_byte, tok_if.second_byte);
    end
  end

  // receiver: random stalls on the byte channel
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // byte monitor: each byte transaction against the oldest predicted byte
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : byte_monitor
    out_byte_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (byte_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b finished %0b",
                                  out_if.data_byte, out_if.last_of_run, out_if.finished));
      end else begin
        want = byte_exp_q.pop_front();
        if (out_if.data_byte !== want.data)
          report_mismatch($sformatf("data_byte %02h, want %02h", out_if.data_byte, want.data));
        if (out_if.last_of_run !== want.last)
          report_mismatch($sformatf("last_of_run %0b, want %0b", out_if.last_of_run,
                                    want.last));
        if (out_if.finished !== want.fin)
          report_mismatch($sformatf("finished %0b, want %0b", out_if.finished, want.fin));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic set_idle(input idle_mix_t mix);
    case (mix)
      IDLE_NONE: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct = 55;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct = 0;
        recv_stall_pct = 55;
      end
      default: begin
        send_idle_pct = 27;
        recv_stall_pct = 27;
      end
    endcase
  endtask

  // length write restarts decoding but keeps the window
  task automatic write_length(input logic [COUNT_W-1:0] len);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= len;
    @(posedge clk);
    cfg_write <= 1'b0;
    out_limit = len;
    out_count = '0;
    halted    = 1'b0;
    gen_bytes = 0;
    @(negedge clk);
  endtask

  task automatic queue_token(input logic [BYTE_W-1:0] b1, input logic [BYTE_W-1:0] b2);
    token_q.push_back('{first: b1, second: b2});
    gen_bytes += (b1 == 8'h00) ? 1 : 32'(b1[7:4]);
  endtask

  // wait for the block to go quiet; zero-length and dropped tokens give no
  // bytes, so a fixed settle follows the last expected byte
  task automatic drain_pipeline();
    int unsigned guard;
    guard = 0;
    while ((token_q.size() != 0 || tok_if.valid || byte_exp_q.size() != 0)
           && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random tokens up to the phase length or budget, then up to three more
  task automatic random_phase(input logic [COUNT_W-1:0] len, input int unsigned budget,
                              input bit long_copies);
    int unsigned       r;
    logic [LEN_W-1:0]  run_len;
    logic [DIST_W-1:0] back_dist;
    write_length(len);
    for (int i = 0; i < budget; i++) begin
      r = $urandom_range(99);
      if (r < (long_copies ? 15 : 35)) begin
        queue_token(8'h00, BYTE_W'($urandom));
      end else if (r < (long_copies ? 17 : 40)) begin
        // zero-length copy
        queue_token({4'h0, LEN_W'($urandom_range(1, 15))}, BYTE_W'($urandom));
      end else begin
        run_len = long_copies ? 4'hF : LEN_W'($urandom_range(1, 15));
        // half near recent output, half anywhere in the window
        back_dist = $urandom_range(1) ? DIST_W'($urandom_range(1, 64)) : DIST_W'($urandom);
        queue_token({run_len, back_dist[11:8]}, back_dist[7:0]);
      end
      if (gen_bytes >= len) break;
    end
    repeat ($urandom_range(0, 3)) queue_token(BYTE_W'($urandom), BYTE_W'($urandom));
    drain_pipeline();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    gen_bytes = 0;
    out_count = '0;
    out_limit = '0;
    halted = 1'b0;
    for (int i = 0; i < WIN_DEPTH; i++) hist_win[i] = '0;
    set_idle(IDLE_NONE);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // literals at the byte extremes, overlapping copy, zero-length copy,
    // distance zero, distance past the output count, then a dropped token
    write_length(24'd40);
    queue_token(8'h00, 8'h00);
    queue_token(8'h00, 8'hFF);
    queue_token(8'h00, 8'hA5);
    queue_token(8'hF0, 8'h01);
    queue_token(8'h10, 8'h03);
    queue_token(8'h0F, 8'hFF);
    queue_token(8'h30, 8'h00);
    queue_token(8'h2F, 8'hFF);
    queue_token(8'hFF, 8'hFF);
    queue_token(8'h00, 8'h5A);
    queue_token(8'hF0, 8'h01);
    drain_pipeline();

    // length zero: a zero-length copy ends decoding with no bytes
    write_length(24'd0);
    queue_token(8'h01, 8'h00);
    queue_token(8'h00, 8'h77);
    drain_pipeline();

    // length zero: the ending token still emits its bytes
    write_length(24'd0);
    queue_token(8'h50, 8'h07);
    drain_pipeline();

    // copy running past the length
    write_length(24'd3);
    queue_token(8'hF0, 8'h02);
    queue_token(8'h00, 8'h11);
    drain_pipeline();

    for (int ph = 0; ph < 10; ph++) begin
      set_idle(idle_mix_t'(ph % 4));
      case (ph)
        3: random_phase(24'd4200, 400, 1'b1);  // output wraps the window
        6: random_phase(COUNT_MAX, 30, 1'b0);  // never finishes
        8: random_phase(24'd0, 3, 1'b0);
        default: random_phase(COUNT_W'($urandom_range(1, 180)), 30, 1'b0);
      endcase
    end

    if (byte_exp_q.size() != 0)
      report_mismatch($sformatf("%0d bytes never arrived", byte_exp_q.size()));
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/lzd_pkg.sv
hdl/lzd_token_if.sv
hdl/lzd_byte_if.sv
hdl/lzd_decode.sv
hdl/lz_token_decompressor_unit.sv
test/testbench.sv
